FILE: hw/rtl/min_tracking_stack_unit_defines.svh
// assertion macros used by the checker file
`ifndef MIN_TRACKING_STACK_UNIT_DEFINES_SVH
`define MIN_TRACKING_STACK_UNIT_DEFINES_SVH

// implication checked at every rising clock edge out of reset
`define MTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min stack check failed");

// condition that must hold in the cycle after the antecedent
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min stack check failed");

`endif

FILE: hw/rtl/mts_pkg.sv
// shared types and constants of the min tracking stack
`timescale 1ns / 1ps

package mts_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;

    typedef logic [1:0] t_status;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_POP_EMPTY = 2'd1;
    localparam t_status ST_PUSH_FULL = 2'd2;

endpackage

FILE: hw/rtl/min_tracking_stack_unit.sv
// min tracking stack: value stack plus minimum history, both in synchronous memories
// output: push, rejected push, ignored pop and pop of the last entry give their word
//   in the cycle after acceptance; a pop that leaves entries reads the new top and new
//   minimum from the two memories into read registers, then loads them into the output register in S_POP
// throughput: one word per cycle while the output is not stalled; S_POP holds the input side
// reset clears depth, history count and handshake state; memory contents stay undefined
`timescale 1ns / 1ps

module min_tracking_stack_unit
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_mode,
    input  logic signed [DATA_W-1:0]  i_push_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DATA_W-1:0]  o_min_value,
    output logic                      o_min_valid,
    output logic signed [DATA_W-1:0]  o_top_value,
    output logic [DEPTH_W-1:0]        o_depth,
    output t_status                   o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    // storage
    logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] hist_mem  [STACK_DEPTH];

    // control and cached tops
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_mcount, n_mcount;
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_min, n_min;
    logic                     r_mdec, n_mdec;

    // read data
    logic signed [DATA_W-1:0] r_rd_val;
    logic signed [DATA_W-1:0] r_rd_min;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_min, n_out_min;
    logic                     r_out_mvalid, n_out_mvalid;
    logic signed [DATA_W-1:0] r_out_top, n_out_top;
    logic [CW-1:0]            r_out_depth, n_out_depth;
    t_status                  r_out_status, n_out_status;

    // memory ports
    logic                     val_we, hist_we, rd_en;
    logic [AW-1:0]            val_waddr, hist_waddr, val_raddr, hist_raddr;
    logic [CW-1:0]            val_raddr_full, hist_raddr_full;
    logic [CW-1:0]            mc_eff;

    logic out_free;
    logic accept_in;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || !out_free;
    assign accept_in = i_valid && !o_stall;

    assign val_raddr_full  = r_count - CW'(2);
    assign hist_raddr_full = r_mcount - CW'(2);
    assign val_raddr       = val_raddr_full[AW-1:0];
    assign hist_raddr      = hist_raddr_full[AW-1:0];
    assign val_waddr       = r_count[AW-1:0];
    assign mc_eff          = (r_count == '0) ? '0 : r_mcount;
    assign hist_waddr      = mc_eff[AW-1:0];

    // operation decode and next state
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_mcount     = r_mcount;
        n_top        = r_top;
        n_min        = r_min;
        n_mdec       = r_mdec;
        n_out_valid  = r_out_valid && i_stall;
        n_out_min    = r_out_min;
        n_out_mvalid = r_out_mvalid;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;
        val_we       = 1'b0;
        hist_we      = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    if (i_mode == 1'b0) begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            // full: state kept, report as is
                            n_out_status = ST_PUSH_FULL;
                            n_out_mvalid = 1'b1;
                            n_out_min    = (r_mcount != '0) ? r_min : '0;
                            n_out_top    = r_top;
                            n_out_depth  = r_count;
                        end else begin
                            val_we   = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_top    = i_push_value;
                            n_mcount = mc_eff;
                            if ((mc_eff == '0) || (i_push_value <= r_min)) begin
                                if (mc_eff != CW'(STACK_DEPTH)) begin
                                    hist_we  = 1'b1;
                                    n_mcount = mc_eff + CW'(1);
                                    n_min    = i_push_value;
                                end
                            end
                            n_out_mvalid = 1'b1;
                            n_out_min    = (n_mcount != '0) ? n_min : '0;
                            n_out_top    = i_push_value;
                            n_out_depth  = n_count;
                        end
                    end else begin
                        if (r_count == '0) begin
                            // pop on empty is ignored
                            n_out_status = ST_POP_EMPTY;
                            n_out_mvalid = 1'b0;
                            n_out_min    = '0;
                            n_out_top    = '0;
                            n_out_depth  = '0;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_mdec  = (r_mcount != '0) && (r_top == r_min);
                            if (n_mdec) begin
                                n_mcount = r_mcount - CW'(1);
                            end
                            if (r_count == CW'(1)) begin
                                // stack becomes empty
                                n_out_mvalid = 1'b0;
                                n_out_min    = '0;
                                n_out_top    = '0;
                                n_out_depth  = '0;
                            end else begin
                                // fetch new top and minimum
                                rd_en       = 1'b1;
                                n_out_valid = r_out_valid && i_stall;
                                n_state     = S_POP;
                            end
                        end
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_top = r_rd_val;
                    if (r_mdec) begin
                        n_min = r_rd_min;
                    end
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_mvalid = 1'b1;
                    n_out_top    = r_rd_val;
                    n_out_min    = (r_mcount != '0) ? n_min : '0;
                    n_out_depth  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            value_mem[val_waddr] <= i_push_value;
        end
        if (rd_en) begin
            r_rd_val <= value_mem[val_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= i_push_value;
        end
        if (rd_en) begin
            r_rd_min <= hist_mem[hist_raddr];
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mcount    <= '0;
            r_mdec      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mcount    <= n_mcount;
            r_mdec      <= n_mdec;
            r_out_valid <= n_out_valid;
        end
        r_top        <= n_top;
        r_min        <= n_min;
        r_out_min    <= n_out_min;
        r_out_mvalid <= n_out_mvalid;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
    end

    assign o_valid     = r_out_valid;
    assign o_min_value = r_out_min;
    assign o_min_valid = r_out_mvalid;
    assign o_top_value = r_out_top;
    assign o_depth     = DEPTH_W'(r_out_depth);
    assign o_status    = r_out_status;

endmodule

FILE: hw/rtl/mts_checker.sv
// port-level checks of the min tracking stack and their binding
`timescale 1ns / 1ps
`include "min_tracking_stack_unit_defines.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [DATA_W-1:0]  o_min_value,
    input logic                      o_min_valid,
    input logic signed [DATA_W-1:0]  o_top_value,
    input logic [DEPTH_W-1:0]        o_depth,
    input t_status                   o_status
);

    // a stalled word stays put
    `MTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_top_value) && $stable(o_min_value) && $stable(o_depth))

    // ignored pop only ever reports an empty stack
    `MTS_ASSERT_IMPLY(a_pop_empty, i_clk, i_rst_n, o_valid && (o_status == ST_POP_EMPTY), (o_depth == '0) && !o_min_valid)

    // an empty stack reports zero minimum and top
    `MTS_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_valid && !o_min_valid, (o_min_value == '0) && (o_top_value == '0))

    // minimum never exceeds the top entry
    `MTS_ASSERT_IMPLY(a_min_le_top, i_clk, i_rst_n, o_valid && o_min_valid, o_min_value <= o_top_value)

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_min_value (o_min_value),
    .o_min_valid (o_min_valid),
    .o_top_value (o_top_value),
    .o_depth     (o_depth),
    .o_status    (o_status)
);
